// ----- hw/rtl/rcsb_pkg.sv -----
// Shared types, constants and saturating helpers for the spline basis unit.
// Depends on nothing; every other file in hw/rtl imports it.
package rcsb_pkg;

   localparam int MAX_KNOTS_DEF = 16;
   localparam int KNOT_W        = 32;
   localparam int DIFF_W        = 33;
   localparam int VAL_W         = 64;
   localparam int PROD_W        = 128;
   localparam int DVD_W         = 65;
   localparam int DVS_W         = 33;

   localparam logic signed [VAL_W-1:0] Q32_ONE = 64'sh0000_0001_0000_0000;
   localparam logic signed [VAL_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] SAT_MIN = 64'sh8000_0000_0000_0000;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   localparam logic REG_KNOT_COUNT = 1'b0;

   // partial product order of the shared multiplier
   localparam logic [1:0] PP_LL = 2'd0;
   localparam logic [1:0] PP_LH = 2'd1;
   localparam logic [1:0] PP_HL = 2'd2;
   localparam logic [1:0] PP_HH = 2'd3;

   typedef struct packed {
      logic                     mode;
      logic [3:0]               knot_index;
      logic signed [KNOT_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]              column;
      logic signed [VAL_W-1:0] basis_value;
      logic                    last;
      logic                    span_error;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [VAL_W-1:0] mag64(input logic signed [VAL_W-1:0] a);
      logic [VAL_W-1:0] r;
      r = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
      return r;
   endfunction

   function automatic logic [DVS_W-1:0] mag33(input logic signed [DIFF_W-1:0] a);
      logic [DVS_W-1:0] r;
      r = a[DIFF_W-1] ? DVS_W'(-a) : DVS_W'(a);
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_sub64(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W-1:0] r;
      r = a - b;
      if ((a[VAL_W-1] != b[VAL_W-1]) && (r[VAL_W-1] != a[VAL_W-1])) begin
         r = a[VAL_W-1] ? SAT_MIN : SAT_MAX;
      end
      return r;
   endfunction

   // Q32.32 product from a magnitude product, truncated toward zero
   function automatic logic signed [VAL_W-1:0] q32_finish(
      input logic [PROD_W-1:0] p,
      input logic              neg);
      logic signed [VAL_W-1:0] m;
      logic signed [VAL_W-1:0] r;
      m = $signed({1'b0, p[94:32]});
      if (p[PROD_W-1:95] != '0) begin
         r = neg ? SAT_MIN : SAT_MAX;
      end else begin
         r = neg ? -m : m;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/rcsb_knot_ram.sv -----
// Knot table: one write port, one read port, read data registered.
// Depends on rcsb_pkg for the knot width.
module rcsb_knot_ram import rcsb_pkg::*; #(
   parameter int DEPTH = MAX_KNOTS_DEF,
   parameter int AW    = $clog2(MAX_KNOTS_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [KNOT_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [KNOT_W-1:0] rd_data
);

   logic [KNOT_W-1:0] mem [DEPTH];
   logic [KNOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rcsb_mul.sv -----
// Shared 64x64 unsigned multiplier: one 32x32 partial product a cycle.
// Depends on rcsb_pkg for widths, partial product codes and the status struct.
module rcsb_mul import rcsb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [VAL_W-1:0]  a,
   input  logic [VAL_W-1:0]  b,
   output unit_status_type   status,
   output logic [PROD_W-1:0] prod
);

   logic              busy_ff;
   logic              done_ff;
   logic [2:0]        phase_ff;
   logic [VAL_W-1:0]  a_ff;
   logic [VAL_W-1:0]  b_ff;
   logic [VAL_W-1:0]  pp_ff;
   logic [1:0]        pp_idx_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [31:0]       a_half;
   logic [31:0]       b_half;
   logic [PROD_W-1:0] pp_shifted;

   always_comb begin
      a_half = phase_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = phase_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (pp_idx_ff) inside
         PP_LL:        pp_shifted = {64'b0, pp_ff};
         PP_LH, PP_HL: pp_shifted = {32'b0, pp_ff, 32'b0};
         default:      pp_shifted = {pp_ff, 64'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= '0;
         end else if (busy_ff) begin
            phase_ff <= phase_ff + 3'd1;
            if (phase_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (phase_ff != 3'd4) begin
            pp_ff     <= VAL_W'(a_half * b_half);
            pp_idx_ff <= phase_ff[1:0];
         end
         if (phase_ff != 3'd0) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
   end

   assign status = '{busy: busy_ff, done: done_ff};
   assign prod   = acc_ff;

endmodule

// ----- hw/rtl/rcsb_div.sv -----
// Restoring divider, one quotient bit a cycle, for the lambda quotient.
// Depends on rcsb_pkg for widths and the status struct.
module rcsb_div import rcsb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output unit_status_type  status,
   output logic [DVD_W-1:0] quot
);

   localparam int CW = $clog2(DVD_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DVD_W-1:0] q_ff;
   logic [DVS_W:0]   rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   rem_sh;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff[DVS_W-1:0], q_ff[DVD_W-1]};
      fits   = rem_sh >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         q_ff   <= {q_ff[DVD_W-2:0], fits};
      end
   end

   assign status = '{busy: busy_ff, done: done_ff};
   assign quot   = q_ff;

endmodule

// ----- hw/rtl/restricted_cubic_spline_basis_unit.sv -----
// Restricted cubic spline basis unit, top level; uses rcsb_pkg, rcsb_knot_ram,
// rcsb_mul and rcsb_div. A knot load is written when accepted. An evaluation
// emits columns 0 and 1, cubes the end-knot distances, then for each inner
// column runs the 65-step divider (not when the end knots coincide) and two
// multiplier passes; one item at a time. Reset clears knot_count and control
// state; no knot reset.
module restricted_cubic_spline_basis_unit import rcsb_pkg::*; #(
   parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(MAX_KNOTS);
   localparam int NW = $clog2(MAX_KNOTS + 1);

   // Evaluation sequencer: fetch end knots, emit columns 0 and 1, cube the end
   // distances, then per inner knot divide if span != 0, cube, multiply twice, emit.
   typedef enum logic [18:0] {
      S_IDLE   = 19'h00001,
      S_RD0    = 19'h00002,
      S_RDL    = 19'h00004,
      S_CAPL   = 19'h00008,
      S_OUT0   = 19'h00010,
      S_OUT1   = 19'h00020,
      S_CUBE_A = 19'h00040,
      S_CUBE_B = 19'h00080,
      S_CUBE_C = 19'h00100,
      S_CL     = 19'h00200,
      S_CL2    = 19'h00400,
      S_KJ_RD  = 19'h00800,
      S_KJ     = 19'h01000,
      S_DIVW   = 19'h02000,
      S_CJ     = 19'h04000,
      S_M1     = 19'h08000,
      S_M1W    = 19'h10000,
      S_M2W    = 19'h20000,
      S_OUTJ   = 19'h40000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [4:0]                knot_count_ff, knot_count_in;
   logic [NW-1:0]             n_eff;
   logic [NW-1:0]             n_ff, n_in, j_ff, j_in;
   logic signed [KNOT_W-1:0]  x_ff, x_in, k0_ff, k0_in, kl_ff, kl_in, kj_ff, kj_in;
   logic signed [DIFF_W-1:0]  d_ff, d_in;
   logic                      err_ff, err_in, lneg_ff, lneg_in;
   logic signed [VAL_W-1:0]   c0_ff, c0_in, cl_ff, cl_in, cube_ff, cube_in;
   logic signed [VAL_W-1:0]   lam_ff, lam_in, v_ff, v_in, oml;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      req_accept, cfg_write, knot_wr, out_free, emit;
   rsp_type                   emit_data;
   logic [AW-1:0]             rd_addr;
   logic [KNOT_W-1:0]         rd_data;
   logic signed [DIFF_W-1:0]  num, span;

   logic                      mul_start;
   logic [VAL_W-1:0]          mul_a, mul_b;
   logic [PROD_W-1:0]         mul_prod;
   unit_status_type           mul_st;
   logic                      div_start;
   logic [DVD_W-1:0]          div_quot;
   unit_status_type           div_st;

   // Configuration: single register, always ready.
   assign pready        = 1'b1;
   assign cfg_write     = psel && penable && pwrite && (paddr[2] == REG_KNOT_COUNT);
   assign knot_count_in = cfg_write ? pwdata[4:0] : knot_count_ff;
   assign prdata        = (paddr[2] == REG_KNOT_COUNT) ? {27'b0, knot_count_ff} : 32'b0;

   // Clamp the column count to the table depth.
   assign n_eff = (32'(knot_count_ff) > 32'(MAX_KNOTS)) ? NW'(MAX_KNOTS) : NW'(knot_count_ff);

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   // Drop loads aimed past the end of the table.
   assign knot_wr    = req_accept && (req_data.mode == MODE_LOAD) &&
                       (32'(req_data.knot_index) < 32'(MAX_KNOTS));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign span     = DIFF_W'(kl_ff) - DIFF_W'(k0_ff);
   assign num      = DIFF_W'(kl_ff) - DIFF_W'(kj_in);
   assign oml      = sat_sub64(Q32_ONE, lam_ff);

   rcsb_knot_ram #(.DEPTH(MAX_KNOTS), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (knot_wr),
      .wr_addr (AW'(req_data.knot_index)),
      .wr_data (req_data.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rcsb_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .status (mul_st),
      .prod   (mul_prod)
   );

   rcsb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({mag33(num), 32'b0}),
      .divisor  (mag33(span)),
      .status   (div_st),
      .quot     (div_quot)
   );

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      n_in      = n_ff;
      j_in      = j_ff;
      x_in      = x_ff;
      k0_in     = k0_ff;
      kl_in     = kl_ff;
      kj_in     = kj_ff;
      d_in      = d_ff;
      err_in    = err_ff;
      lneg_in   = lneg_ff;
      c0_in     = c0_ff;
      cl_in     = cl_ff;
      cube_in   = cube_ff;
      lam_in    = lam_ff;
      v_in      = v_ff;
      rd_addr   = '0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      emit      = 1'b0;
      emit_data = '{column: 4'd0, basis_value: Q32_ONE, last: 1'b0, span_error: err_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_data.mode == MODE_EVAL) && (n_eff != '0)) begin
               x_in     = req_data.value;
               n_in     = n_eff;
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            state_in = S_RDL;
         end
         S_RDL: begin
            rd_addr  = AW'(n_ff - NW'(1));
            k0_in    = rd_data;
            state_in = S_CAPL;
         end
         S_CAPL: begin
            kl_in    = rd_data;
            err_in   = (n_ff >= NW'(3)) && (k0_ff == $signed(rd_data));
            state_in = S_OUT0;
         end
         S_OUT0: begin
            emit_data.last = (n_ff == NW'(1));
            if (out_free) begin
               emit     = 1'b1;
               state_in = emit_data.last ? S_IDLE : S_OUT1;
            end
         end
         S_OUT1: begin
            emit_data.column      = 4'd1;
            emit_data.basis_value = {{16{x_ff[KNOT_W-1]}}, x_ff, 16'b0};
            emit_data.last        = (n_ff == NW'(2));
            if (out_free) begin
               emit = 1'b1;
               if (emit_data.last) begin
                  state_in = S_IDLE;
               end else begin
                  d_in     = DIFF_W'(x_ff) - DIFF_W'(k0_ff);
                  ret_in   = S_CL;
                  state_in = S_CUBE_A;
               end
            end
         end
         // Cube of the positive part of d_ff, Q16.16 in, Q32.32 out.
         S_CUBE_A: begin
            if (d_ff[DIFF_W-1] || (d_ff == '0)) begin
               cube_in  = '0;
               state_in = ret_ff;
            end else if (d_ff[DIFF_W-2:27] != '0) begin
               cube_in  = SAT_MAX;
               state_in = ret_ff;
            end else begin
               mul_start = 1'b1;
               mul_a     = VAL_W'(unsigned'(d_ff));
               mul_b     = VAL_W'(unsigned'(d_ff));
               state_in  = S_CUBE_B;
            end
         end
         S_CUBE_B: begin
            if (mul_st.done) begin
               mul_start = 1'b1;
               mul_a     = mul_prod[VAL_W-1:0];
               mul_b     = VAL_W'(unsigned'(d_ff));
               state_in  = S_CUBE_C;
            end
         end
         S_CUBE_C: begin
            if (mul_st.done) begin
               cube_in  = (mul_prod[PROD_W-1:79] != '0) ? SAT_MAX :
                          $signed({1'b0, mul_prod[78:16]});
               state_in = ret_ff;
            end
         end
         S_CL: begin
            c0_in    = cube_ff;
            d_in     = DIFF_W'(x_ff) - DIFF_W'(kl_ff);
            ret_in   = S_CL2;
            state_in = S_CUBE_A;
         end
         S_CL2: begin
            cl_in    = cube_ff;
            j_in     = NW'(1);
            state_in = S_KJ_RD;
         end
         S_KJ_RD: begin
            rd_addr  = AW'(j_ff);
            state_in = S_KJ;
         end
         S_KJ: begin
            kj_in = rd_data;
            if (err_ff) begin
               lam_in   = '0;
               state_in = S_CJ;
            end else begin
               div_start = 1'b1;
               lneg_in   = num[DIFF_W-1] ^ span[DIFF_W-1];
               state_in  = S_DIVW;
            end
         end
         S_DIVW: begin
            if (div_st.done) begin
               if (div_quot[DVD_W-1:63] != '0) begin
                  lam_in = lneg_ff ? -SAT_MAX : SAT_MAX;
               end else begin
                  lam_in = lneg_ff ? -$signed({1'b0, div_quot[62:0]}) :
                                      $signed({1'b0, div_quot[62:0]});
               end
               state_in = S_CJ;
            end
         end
         S_CJ: begin
            d_in     = DIFF_W'(x_ff) - DIFF_W'(kj_ff);
            ret_in   = S_M1;
            state_in = S_CUBE_A;
         end
         S_M1: begin
            v_in      = cube_ff;
            mul_start = 1'b1;
            mul_a     = mag64(lam_ff);
            mul_b     = unsigned'(c0_ff);
            state_in  = S_M1W;
         end
         S_M1W: begin
            if (mul_st.done) begin
               v_in      = sat_sub64(v_ff, q32_finish(mul_prod, lam_ff[VAL_W-1]));
               mul_start = 1'b1;
               mul_a     = mag64(oml);
               mul_b     = unsigned'(cl_ff);
               state_in  = S_M2W;
            end
         end
         S_M2W: begin
            if (mul_st.done) begin
               v_in     = sat_sub64(v_ff, q32_finish(mul_prod, oml[VAL_W-1]));
               state_in = S_OUTJ;
            end
         end
         S_OUTJ: begin
            emit_data.column      = 4'(j_ff + NW'(1));
            emit_data.basis_value = v_ff;
            emit_data.last        = ((NW+1)'(j_ff) + (NW+1)'(2)) == (NW+1)'(n_ff);
            if (out_free) begin
               emit = 1'b1;
               if (emit_data.last) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + NW'(1);
                  state_in = S_KJ_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: hold while stalled, advance on emit.
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = emit ? emit_data : rsp_data_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         knot_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         rsp_valid_ff  <= rsp_valid_in;
         knot_count_ff <= knot_count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      j_ff        <= j_in;
      x_ff        <= x_in;
      k0_ff       <= k0_in;
      kl_ff       <= kl_in;
      kj_ff       <= kj_in;
      d_ff        <= d_in;
      err_ff      <= err_in;
      lneg_ff     <= lneg_in;
      c0_ff       <= c0_in;
      cl_ff       <= cl_in;
      cube_ff     <= cube_in;
      lam_ff      <= lam_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // The final column of an evaluation returns the sequencer to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_data.last) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after last column");

   // No lambda division when the end knots coincide.
   a_no_div_on_err: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !err_ff)
      else $error("division started with zero span");

   // The shared multiplier is never restarted while busy.
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_st.busy)
      else $error("multiplier started while busy");

   // Divider and multiplier never run together.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_st.busy && mul_st.busy))
      else $error("divider and multiplier busy at once");
`endif

endmodule
